// ----- rtl/core/fastq_position_quality_histogram_macros.svh -----
// Assertion macros for the FASTQ per-position quality histogram.
`ifndef FASTQ_POSITION_QUALITY_HISTOGRAM_MACROS_SVH
`define FASTQ_POSITION_QUALITY_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define FPQH_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// Check that a condition holds whenever its trigger holds.
`define FPQH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FPQH_ASSERT(label, cond, msg)
`define FPQH_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ----- rtl/core/fpqh_pkg.sv -----
// Shared constants, types and functions of the FASTQ per-position quality histogram.
package fpqh_pkg;

    localparam int DEF_MAX_READ_LEN = 1024;
    localparam int DEF_QUAL_MAX     = 42;
    localparam int DEF_COUNT_WIDTH  = 32;

    localparam int NUM_BASE_BINS = 5;
    localparam int Q20_LEVEL     = 20;
    localparam int Q30_LEVEL     = 30;

    localparam int OFFSET_W = 7;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd33;

    localparam int CHAR_W     = 8;
    localparam int RPOS_W     = 10;
    localparam int RBIN_W     = 6;
    localparam int IN_DATA_W  = 2 * CHAR_W + RPOS_W + RBIN_W;
    localparam int CNT_OUT_W  = 32;
    localparam int TOTAL_W    = 48;
    localparam int LEN_OUT_W  = 11;
    localparam int OUT_USED_W = CNT_OUT_W + 4 * TOTAL_W + 2 * LEN_OUT_W + 3;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    localparam logic [CHAR_W-1:0] CH_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_T = 8'h54;
    localparam logic [CHAR_W-1:0] CH_C = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G = 8'h47;
    localparam logic [CHAR_W-1:0] CH_N = 8'h4E;

    localparam logic [2:0] SLOT_A = 3'd0;
    localparam logic [2:0] SLOT_T = 3'd1;
    localparam logic [2:0] SLOT_C = 3'd2;
    localparam logic [2:0] SLOT_G = 3'd3;
    localparam logic [2:0] SLOT_N = 3'd4;

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
    } base_slot_t;

    function automatic base_slot_t base_decode(input logic [CHAR_W-1:0] ch);
        base_slot_t r;
        r.hit = 1'b1;
        unique case (ch)
            CH_A:    r.slot = SLOT_A;
            CH_T:    r.slot = SLOT_T;
            CH_C:    r.slot = SLOT_C;
            CH_G:    r.slot = SLOT_G;
            CH_N:    r.slot = SLOT_N;
            default:
            begin
                r.hit  = 1'b0;
                r.slot = SLOT_A;
            end
        endcase
        return r;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc_total(input logic [TOTAL_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/core/fpqh_ram.sv -----
// Simple dual-port synchronous RAM with registered read.
module fpqh_ram
    import fpqh_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_READ_LEN * NUM_BASE_BINS,
    parameter int WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read returns the old word when the same entry is written in this cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/fastq_position_quality_histogram.sv -----
// Top level of the FASTQ per-position base and quality histogram.
// One request enters per cycle while s_tready is high, which it is not during the
// clearing pass or while stage 1 waits on a stalled output; its result passes through
// the stage 1 register and the output register. The pace is set by the read-modify-write
// of two RAMs (a base RAM of MAX_READ_LEN*5 counters and a quality RAM of
// MAX_READ_LEN*(QUAL_MAX+1) counters), each read once and written once per cycle with
// forwarding of the entry written in the same cycle. A count request bumps at most one
// base counter and at most one quality counter of the current read position; a read-out
// request returns one counter. After reset a clearing pass zeroes both RAMs with
// s_tready low; configuration writes are taken throughout.
`include "fastq_position_quality_histogram_macros.svh"

module fastq_position_quality_histogram
    import fpqh_pkg::*;
#(
    parameter int MAX_READ_LEN = DEF_MAX_READ_LEN,
    parameter int QUAL_MAX     = DEF_QUAL_MAX,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [OFFSET_W-1:0]   cfg_wdata,   // quality_offset
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // base_char, qual_char, read_position, read_bin
    input  logic                  s_tuser,     // opcode
    input  logic                  s_tlast,     // end_of_read
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // counter_value, reads_total, bases_total, q20_total, q30_total, min_length,
    // max_length, bad_base, bad_quality, position_overflow, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int POS_W   = $clog2(MAX_READ_LEN + 1);
    localparam int ROW_W   = $clog2(MAX_READ_LEN);
    localparam int QBINS   = QUAL_MAX + 1;
    localparam int NUM_BINS = QBINS + NUM_BASE_BINS;
    localparam int B_DEPTH = MAX_READ_LEN * NUM_BASE_BINS;
    localparam int Q_DEPTH = MAX_READ_LEN * QBINS;
    localparam int BA_W    = $clog2(B_DEPTH);
    localparam int QA_W    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic             read_op;
        logic             rd_ok;
        logic             rd_sel_q;
        logic             b_we;
        logic             q_we;
        logic [BA_W-1:0]  b_addr;
        logic [QA_W-1:0]  q_addr;
        logic             counted;
        logic             eor;
        logic [POS_W-1:0] len;
        logic             bad_base;
        logic             bad_qual;
        logic             ovf;
        logic             q20;
        logic             q30;
        logic             b_fwd;
        logic             q_fwd;
    } s1_t;

    // input unpack
    logic [CHAR_W-1:0] base_char;
    logic [CHAR_W-1:0] qual_char;
    logic [RPOS_W-1:0] rd_pos;
    logic [RBIN_W-1:0] rd_bin;
    op_t               opcode;

    // control state
    logic [OFFSET_W-1:0] offset_reg;
    logic                clr_reg;
    logic [QA_W-1:0]     clr_addr_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                s1_valid_reg;
    s1_t                 s1_reg;
    s1_t                 s1_next;
    logic [COUNT_WIDTH-1:0] b_fwd_data_reg;
    logic [COUNT_WIDTH-1:0] q_fwd_data_reg;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;

    logic [TOTAL_W-1:0] read_count_reg, read_count_next;
    logic [TOTAL_W-1:0] base_count_reg, base_count_next;
    logic [TOTAL_W-1:0] q20_count_reg, q20_count_next;
    logic [TOTAL_W-1:0] q30_count_reg, q30_count_next;
    logic [POS_W-1:0]   shortest_reg, shortest_next;
    logic [POS_W-1:0]   longest_reg, longest_next;

    // handshake
    logic out_free;
    logic s1_fire;
    logic in_ready;
    logic in_fire;

    // stage 0 decode
    base_slot_t         bslot;
    logic signed [8:0]  score;
    logic               score_neg;
    logic               score_hi;
    logic               ovf;
    logic               count_op;
    logic               counted;
    logic [POS_W-1:0]   pos_after;
    logic [ROW_W-1:0]   row;
    logic [BA_W-1:0]    b_cnt_addr;
    logic [QA_W-1:0]    q_cnt_addr;
    logic               rd_in_range;
    logic               rd_sel_q;
    logic [ROW_W-1:0]   rd_row;
    logic [BA_W-1:0]    rd_b_addr;
    logic [QA_W-1:0]    rd_q_addr;
    logic [BA_W-1:0]    b_addr_s0;
    logic [QA_W-1:0]    q_addr_s0;

    // memory ports
    logic                   b_wr_en, q_wr_en;
    logic [BA_W-1:0]        b_wr_addr;
    logic [QA_W-1:0]        q_wr_addr;
    logic [COUNT_WIDTH-1:0] b_wr_data, q_wr_data;
    logic [COUNT_WIDTH-1:0] b_rdata, q_rdata;
    logic [COUNT_WIDTH-1:0] b_cur, q_cur;
    logic [COUNT_WIDTH-1:0] b_wdata, q_wdata;
    logic [CNT_OUT_W-1:0]   counter_value;

    assign base_char = s_tdata[7:0];
    assign qual_char = s_tdata[15:8];
    assign rd_pos    = s_tdata[25:16];
    assign rd_bin    = s_tdata[31:26];
    assign opcode    = op_t'(s_tuser);

    assign out_free = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !clr_reg && (!s1_valid_reg || s1_fire);
    assign in_fire  = s_tvalid && in_ready;
    assign s_tready = in_ready;

    // ---------------- stage 0: decode and address ----------------
    always_comb
    begin
        bslot     = base_decode(base_char);
        score     = $signed({1'b0, qual_char}) - $signed({2'b00, offset_reg});
        score_neg = score[8];
        score_hi  = !score_neg && (score[7:0] > 8'(QUAL_MAX));
        ovf       = (pos_reg == POS_W'(MAX_READ_LEN));
        count_op  = (opcode == OP_COUNT);
        counted   = count_op && !ovf;
        pos_after = ovf ? pos_reg : pos_reg + 1'b1;
        row       = ROW_W'(pos_reg);

        b_cnt_addr = BA_W'(row) * BA_W'(NUM_BASE_BINS) + BA_W'(bslot.slot);
        q_cnt_addr = QA_W'(row) * QA_W'(QBINS) + QA_W'(score[7:0]);

        rd_in_range = (int'(rd_pos) < MAX_READ_LEN) && (int'(rd_bin) < NUM_BINS);
        rd_sel_q    = (rd_bin >= RBIN_W'(NUM_BASE_BINS));
        rd_row      = ROW_W'(rd_pos);
        rd_b_addr   = BA_W'(rd_row) * BA_W'(NUM_BASE_BINS) + BA_W'(rd_bin);
        rd_q_addr   = QA_W'(rd_row) * QA_W'(QBINS)
                    + QA_W'(rd_bin - RBIN_W'(NUM_BASE_BINS));

        b_addr_s0 = count_op ? b_cnt_addr : rd_b_addr;
        q_addr_s0 = count_op ? q_cnt_addr : rd_q_addr;

        s1_next.read_op  = !count_op;
        s1_next.rd_ok    = rd_in_range;
        s1_next.rd_sel_q = rd_sel_q;
        s1_next.b_we     = counted && bslot.hit;
        s1_next.q_we     = counted && !score_neg && !score_hi;
        s1_next.b_addr   = b_addr_s0;
        s1_next.q_addr   = q_addr_s0;
        s1_next.counted  = counted;
        s1_next.eor      = count_op && s_tlast;
        s1_next.len      = pos_after;
        s1_next.bad_base = counted && !bslot.hit;
        s1_next.bad_qual = counted && (score_neg || score_hi);
        s1_next.ovf      = count_op && ovf;
        s1_next.q20      = counted && !score_neg && (score[7:0] >= 8'(Q20_LEVEL));
        s1_next.q30      = counted && !score_neg && (score[7:0] >= 8'(Q30_LEVEL));
        // forward the word that stage 1 writes at the same edge as this read
        s1_next.b_fwd    = s1_valid_reg && s1_reg.b_we && (s1_reg.b_addr == b_addr_s0);
        s1_next.q_fwd    = s1_valid_reg && s1_reg.q_we && (s1_reg.q_addr == q_addr_s0);

        pos_next = pos_reg;
        if (in_fire && count_op)
        begin
            pos_next = s_tlast ? '0 : pos_after;
        end
    end

    // ---------------- memories ----------------
    always_comb
    begin
        if (clr_reg)
        begin
            b_wr_en   = (int'(clr_addr_reg) < B_DEPTH);
            b_wr_addr = BA_W'(clr_addr_reg);
            b_wr_data = '0;
            q_wr_en   = 1'b1;
            q_wr_addr = clr_addr_reg;
            q_wr_data = '0;
        end
        else
        begin
            b_wr_en   = s1_fire && s1_reg.b_we;
            b_wr_addr = s1_reg.b_addr;
            b_wr_data = b_wdata;
            q_wr_en   = s1_fire && s1_reg.q_we;
            q_wr_addr = s1_reg.q_addr;
            q_wr_data = q_wdata;
        end
    end

    fpqh_ram #(
        .DEPTH (B_DEPTH),
        .WIDTH (COUNT_WIDTH)
    ) u_base_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .rd_en   (in_fire),
        .rd_addr (b_addr_s0),
        .rd_data (b_rdata)
    );

    fpqh_ram #(
        .DEPTH (Q_DEPTH),
        .WIDTH (COUNT_WIDTH)
    ) u_qual_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (in_fire),
        .rd_addr (q_addr_s0),
        .rd_data (q_rdata)
    );

    // ---------------- stage 1: modify and totals ----------------
    always_comb
    begin
        b_cur   = s1_reg.b_fwd ? b_fwd_data_reg : b_rdata;
        q_cur   = s1_reg.q_fwd ? q_fwd_data_reg : q_rdata;
        b_wdata = (&b_cur) ? b_cur : b_cur + 1'b1;
        q_wdata = (&q_cur) ? q_cur : q_cur + 1'b1;

        counter_value = '0;
        if (s1_reg.read_op && s1_reg.rd_ok)
        begin
            counter_value = CNT_OUT_W'(s1_reg.rd_sel_q ? q_cur : b_cur);
        end

        read_count_next = read_count_reg;
        base_count_next = base_count_reg;
        q20_count_next  = q20_count_reg;
        q30_count_next  = q30_count_reg;
        shortest_next   = shortest_reg;
        longest_next    = longest_reg;
        if (s1_fire)
        begin
            if (s1_reg.counted)
            begin
                base_count_next = sat_inc_total(base_count_reg);
            end
            if (s1_reg.q20)
            begin
                q20_count_next = sat_inc_total(q20_count_reg);
            end
            if (s1_reg.q30)
            begin
                q30_count_next = sat_inc_total(q30_count_reg);
            end
            if (s1_reg.eor)
            begin
                read_count_next = sat_inc_total(read_count_reg);
                if (s1_reg.len < shortest_reg)
                begin
                    shortest_next = s1_reg.len;
                end
                if (s1_reg.len > longest_reg)
                begin
                    longest_next = s1_reg.len;
                end
            end
        end

        m_data_next = {OUT_PAD_W'(0), s1_reg.ovf, s1_reg.bad_qual, s1_reg.bad_base,
                       LEN_OUT_W'(longest_next), LEN_OUT_W'(shortest_next),
                       q30_count_next, q20_count_next, base_count_next, read_count_next,
                       counter_value};
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= OFFSET_RESET;
            clr_reg        <= 1'b1;
            clr_addr_reg   <= '0;
            pos_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            read_count_reg <= '0;
            base_count_reg <= '0;
            q20_count_reg  <= '0;
            q30_count_reg  <= '0;
            shortest_reg   <= POS_W'(MAX_READ_LEN);
            longest_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                offset_reg <= cfg_wdata;
            end
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == QA_W'(Q_DEPTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            pos_reg <= pos_next;
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            read_count_reg <= read_count_next;
            base_count_reg <= base_count_next;
            q20_count_reg  <= q20_count_next;
            q30_count_reg  <= q30_count_next;
            shortest_reg   <= shortest_next;
            longest_reg    <= longest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg         <= s1_next;
            b_fwd_data_reg <= b_wdata;
            q_fwd_data_reg <= q_wdata;
        end
        if (s1_fire)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    `FPQH_ASSERT_IMP(a_idle_in_clear, clr_reg, !s1_valid_reg && !m_valid_reg, "busy during clear")
    `FPQH_ASSERT(a_pos_bound, pos_reg <= POS_W'(MAX_READ_LEN), "read position beyond maximum")
    `FPQH_ASSERT_IMP(a_len_order, read_count_reg != '0, shortest_reg <= longest_reg, "len order")
    `FPQH_ASSERT(a_q30_order, q30_count_reg <= q20_count_reg, "q30 total above q20 total")
    `FPQH_ASSERT(a_q20_order, q20_count_reg <= base_count_reg, "q20 total above base total")

endmodule
